### rtl/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define AST_IMP(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define AST_NXT(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");

`endif

### rtl/slsi_pkg.sv
// Types, codes and helpers shared by the sorted list store.
package slsi_pkg;

  localparam int IN_VALUE_W = 32;
  localparam int COUNT_W    = 7;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_DELETE = 1'b1;

  typedef struct packed {
    logic                         func;
    logic signed [IN_VALUE_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic               ok;
    logic [COUNT_W-1:0] count;
  } out_t;

  typedef struct packed {
    logic eval;
    logic update;
    logic ins;
  } cell_ctl_t;

  function automatic int tree_levels(int n);
    int lg;
    lg = $clog2(n);
    if (n <= 8) begin
      return 1;
    end
    return (lg + 2) / 3;
  endfunction

endpackage

### rtl/slsi_cell.sv
// One storage cell of the sorted chain: an entry, its compare flags and its shift logic.
module slsi_cell
  import slsi_pkg::*;
#(
  parameter int IDX = 0,
  parameter int VW  = 32,
  parameter int HW  = 7
) (
  input  logic          clk,
  input  cell_ctl_t     ctl,
  input  logic [VW-1:0] v,
  input  logic [HW-1:0] held,
  input  logic [VW-1:0] prev_entry,
  input  logic          prev_gt,
  input  logic [VW-1:0] next_entry,
  output logic [VW-1:0] entry,
  output logic          gt,
  output logic          eq
);

  localparam logic [HW-1:0] IDX_H = HW'(IDX);

  logic ge;
  logic occ;

  assign occ = (held > IDX_H);

  always_ff @(posedge clk) begin
    if (ctl.eval) begin
      gt <= occ && ($signed(entry) > $signed(v));
      ge <= occ && ($signed(entry) >= $signed(v));
      eq <= occ && (entry == v);
    end
    if (ctl.update) begin
      if (ctl.ins) begin
        if (prev_gt) begin
          entry <= prev_entry;
        end else if (gt || (held == IDX_H)) begin
          entry <= v;
        end
      end else if (ge) begin
        entry <= next_entry;
      end
    end
  end

endmodule

### rtl/slsi_or_tree.sv
// Registered eight-way OR tree that reduces the cells' match flags.
module slsi_or_tree
  import slsi_pkg::*;
#(
  parameter int N = 64
) (
  input  logic         clk,
  input  logic [N-1:0] flags,
  output logic         any
);

  localparam int LEVELS = tree_levels(N);

  logic [N-1:0] lvl [LEVELS+1];

  assign lvl[0] = flags;
  assign any    = lvl[LEVELS][0];

  for (genvar l = 0; l < LEVELS; l++) begin : g_lvl
    localparam int W  = (N + (1 << (3 * l)) - 1) >> (3 * l);
    localparam int WN = (N + (1 << (3 * (l + 1))) - 1) >> (3 * (l + 1));
    logic [N-1:0] nxt;

    always_comb begin
      nxt = '0;
      for (int j = 0; j < WN; j++) begin
        for (int k = 0; k < 8; k++) begin
          if (8 * j + k < W) begin
            nxt[j] = nxt[j] | lvl[l][8 * j + k];
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      lvl[l+1] <= nxt;
    end
  end

endmodule

### rtl/sorted_list_insert_delete.sv
// Top level of the sorted list store: control sequencer, cell chain and result register.
//
// Keeps up to DEPTH signed values in ascending order in a chain of cells.
// Input channel in_valid/in_stall/in_data carries one operation per transaction:
// func insert places the value after all entries not greater than it, func delete
// removes the lowest-placed equal entry. Each transaction yields exactly one result
// transaction on out_valid/out_stall/out_data with ok and the count held afterwards.
// An insert into a full store, or a delete of an absent value, changes nothing and
// returns ok low with the unchanged count.
// The result is registered after the states S_EVAL, S_TREE and S_APPLY, where S_TREE
// waits for the L = ceil(log8(DEPTH)) levels of the registered OR tree that tells
// whether any cell matched the value (L = 2 at DEPTH 64); out_stall can hold S_APPLY.
// No new transaction is taken until the result has been written; all cells compare at
// once and shift together, so apart from out_stall the match tree alone sets the wait.
// in_stall is high from acceptance until the result has been written.
// When out_stall holds a result, the block waits before writing the next result and
// the held result does not change.
// Reset (rst, synchronous) empties the store, clears out_valid and holds in_stall
// high while rst is high; the entries themselves are not cleared.
module sorted_list_insert_delete
  import slsi_pkg::*;
#(
  parameter int DEPTH       = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  localparam int HW     = $clog2(DEPTH + 1);
  localparam int LEVELS = tree_levels(DEPTH);
  localparam int TW     = $clog2(LEVELS + 1);
  localparam logic [HW-1:0] DEPTH_H = HW'(DEPTH);
  localparam logic [TW-1:0] WAIT_LAST = TW'(LEVELS - 1);

  typedef enum logic [1:0] {S_IDLE, S_EVAL, S_TREE, S_APPLY} state_t;

  state_t                 state;
  logic   [TW-1:0]        cnt;
  logic   [HW-1:0]        held;
  logic   [HW-1:0]        held_next;
  logic   [VALUE_WIDTH-1:0] v;
  logic   [VALUE_WIDTH-1:0] v_in;
  logic                   ins;
  logic                   full;
  logic                   found;
  logic                   ok_now;
  logic                   out_free;
  cell_ctl_t              ctl;
  logic   [COUNT_W-1:0]   count_next;

  logic [VALUE_WIDTH-1:0] ent [DEPTH];
  logic [DEPTH-1:0]       gt_f;
  logic [DEPTH-1:0]       eq_f;

  if (VALUE_WIDTH > IN_VALUE_W) begin : g_ext
    assign v_in = {{(VALUE_WIDTH - IN_VALUE_W){in_data.value[IN_VALUE_W-1]}}, in_data.value};
  end else begin : g_trunc
    assign v_in = in_data.value[VALUE_WIDTH-1:0];
  end

  if (HW >= COUNT_W) begin : g_cnt_cut
    assign count_next = held_next[COUNT_W-1:0];
  end else begin : g_cnt_ext
    assign count_next = {{(COUNT_W - HW){1'b0}}, held_next};
  end

  assign in_stall = rst || (state != S_IDLE);
  assign full     = (held == DEPTH_H);
  assign out_free = !(out_valid && out_stall);
  assign ok_now   = ins ? !full : found;

  always_comb begin
    held_next = held;
    if (ok_now) begin
      held_next = ins ? held + HW'(1) : held - HW'(1);
    end
  end

  assign ctl.eval   = (state == S_EVAL);
  assign ctl.update = (state == S_APPLY) && out_free && ok_now;
  assign ctl.ins    = ins;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [VALUE_WIDTH-1:0] pe;
    logic                   pg;
    logic [VALUE_WIDTH-1:0] ne;
    if (i == 0) begin : g_first
      assign pe = v;
      assign pg = 1'b0;
    end else begin : g_mid
      assign pe = ent[i-1];
      assign pg = gt_f[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign ne = ent[i];
    end else begin : g_up
      assign ne = ent[i+1];
    end
    slsi_cell #(
      .IDX(i),
      .VW (VALUE_WIDTH),
      .HW (HW)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .v         (v),
      .held      (held),
      .prev_entry(pe),
      .prev_gt   (pg),
      .next_entry(ne),
      .entry     (ent[i]),
      .gt        (gt_f[i]),
      .eq        (eq_f[i])
    );
  end

  slsi_or_tree #(
    .N(DEPTH)
  ) u_tree (
    .clk  (clk),
    .flags(eq_f),
    .any  (found)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      held      <= '0;
      out_valid <= 1'b0;
      cnt       <= '0;
    end else begin
      if (state == S_APPLY && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            v     <= v_in;
            ins   <= (in_data.func == FUNC_INSERT);
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          cnt   <= '0;
          state <= S_TREE;
        end
        S_TREE: begin
          if (cnt == WAIT_LAST) begin
            state <= S_APPLY;
          end else begin
            cnt <= cnt + TW'(1);
          end
        end
        S_APPLY: begin
          if (out_free) begin
            held           <= held_next;
            out_data.ok    <= ok_now;
            out_data.count <= count_next;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/slsi_checker.sv
// Port-level checker for the sorted list store and its bind to the top level.
`include "assert_macros.svh"

module slsi_checker
  import slsi_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input out_t out_data
);

  logic               seen;
  logic [COUNT_W-1:0] last_count;
  logic               in_acc;
  logic               out_acc;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= 1'b0;
    end else if (out_acc) begin
      seen       <= 1'b1;
      last_count <= out_data.count;
    end
  end

  `AST_NXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_data))
  `AST_NXT(a_one_at_a_time, clk, rst, in_acc, in_stall)
  `AST_IMP(a_count_bound, clk, rst, out_valid, (DEPTH > 127) || (out_data.count <= DEPTH))
  `AST_IMP(a_fail_keeps, clk, rst, out_valid && seen && !out_data.ok, out_data.count == last_count)

endmodule

bind sorted_list_insert_delete slsi_checker #(.DEPTH(DEPTH)) u_slsi_checker (.*);

### test/tb_sorted_list_insert_delete.sv
// Testbench for the sorted list store: random insert and delete traffic checked against a tracked list.
module tb_sorted_list_insert_delete;
  import slsi_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH       = 64;
  localparam int VALUE_WIDTH = 32;

  typedef logic signed [VALUE_WIDTH-1:0] word_t;
  typedef logic signed [IN_VALUE_W-1:0] in_word_t;

  class sorted_list_tracker;
    word_t contents[$];
    out_t  expected_replies[$];
    int    mismatches;
    int    checked;
    int    refused_full;
    int    absent_deletes;
    int    peak;

    function int outstanding();
      return expected_replies.size();
    endfunction

    function void flag(string what);
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch at %0t ns: %s", $time, what);
      end
    endfunction

    function void note_operation(in_t op);
      word_t v;
      out_t  reply;
      int    pos;
      v = word_t'(op.value);
      reply.ok = 1'b0;
      pos = 0;
      if (op.func == FUNC_INSERT) begin
        if (contents.size() < DEPTH) begin
          while (pos < contents.size() && contents[pos] <= v) pos++;
          contents.insert(pos, v);
          reply.ok = 1'b1;
        end else begin
          refused_full++;
        end
      end else begin
        while (pos < contents.size() && contents[pos] != v) pos++;
        if (pos < contents.size()) begin
          contents.delete(pos);
          reply.ok = 1'b1;
        end else begin
          absent_deletes++;
        end
      end
      if (contents.size() > peak) peak = contents.size();
      reply.count = COUNT_W'(contents.size());
      expected_replies.push_back(reply);
    endfunction

    function void check_reply(out_t got);
      out_t want;
      checked++;
      if (expected_replies.size() == 0) begin
        flag($sformatf("unexpected result ok=%0b count=%0d", got.ok, got.count));
        return;
      end
      want = expected_replies.pop_front();
      if (got.ok !== want.ok || got.count !== want.count) begin
        flag($sformatf("expected ok=%0b count=%0d, got ok=%0b count=%0d",
                       want.ok, want.count, got.ok, got.count));
      end
    endfunction
  endclass

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic in_valid  = 1'b0;
  in_t  in_data   = '0;
  logic out_stall = 1'b0;
  logic in_stall;
  logic out_valid;
  out_t out_data;

  int       pace     = 12;
  int       hold_len = 0;
  int       sent     = 0;
  in_word_t recent_values[$];

  sorted_list_tracker tracker = new();

  sorted_list_insert_delete #(
    .DEPTH      (DEPTH),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) tracker.note_operation(in_data);
      if (out_valid && !out_stall) tracker.check_reply(out_data);
    end
  end

  function automatic in_t make_op(logic func, in_word_t value);
    in_t op;
    op.func  = func;
    op.value = value;
    return op;
  endfunction

  function automatic in_word_t pick_value();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 35 && recent_values.size() > 0) begin
      return recent_values[$urandom_range(0, recent_values.size() - 1)];
    end else if (sel < 65) begin
      return in_word_t'(int'($urandom_range(0, 15)) - 8);
    end else if (sel < 75) begin
      case ($urandom_range(0, 3))
        0:       return 32'sh8000_0000;
        1:       return 32'sh7fff_ffff;
        2:       return '0;
        default: return -1;
      endcase
    end
    return in_word_t'($urandom);
  endfunction

  function automatic in_t random_op(int insert_pct);
    in_t op;
    op.value = pick_value();
    if ($urandom_range(0, 99) < insert_pct) begin
      op.func = FUNC_INSERT;
      recent_values.push_back(op.value);
      if (recent_values.size() > 96) void'(recent_values.pop_front());
    end else begin
      op.func = FUNC_DELETE;
    end
    return op;
  endfunction

  task automatic send_op(in_t op);
    int gap;
    gap = $urandom_range(0, pace);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= op;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  task automatic run_phase(int n, int insert_pct, int pace_max);
    pace = pace_max;
    repeat (n) send_op(random_op(insert_pct));
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (tracker.outstanding() != 0) @(posedge clk);
  endtask

  initial begin : result_sink
    int n;
    while (rst) @(posedge clk);
    forever begin
      if (hold_len > 0) begin
        out_stall <= 1'b1;
        repeat (hold_len) @(posedge clk);
        hold_len = 0;
      end
      n = $urandom_range(0, pace);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    #4_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    pace = 3;
    send_op(make_op(FUNC_DELETE, 0));
    send_op(make_op(FUNC_INSERT, 0));
    send_op(make_op(FUNC_INSERT, 32'sh8000_0000));
    send_op(make_op(FUNC_INSERT, 32'sh7fff_ffff));
    send_op(make_op(FUNC_INSERT, -1));
    send_op(make_op(FUNC_INSERT, 1));
    send_op(make_op(FUNC_INSERT, 0));
    send_op(make_op(FUNC_INSERT, 0));
    send_op(make_op(FUNC_INSERT, 32'sh7fff_ffff));
    send_op(make_op(FUNC_DELETE, 0));
    send_op(make_op(FUNC_DELETE, 5));
    send_op(make_op(FUNC_DELETE, 32'sh8000_0000));
    send_op(make_op(FUNC_DELETE, 32'sh7fff_ffff));
    send_op(make_op(FUNC_DELETE, -1));
    send_op(make_op(FUNC_INSERT, 32'sh5555_5555));
    send_op(make_op(FUNC_INSERT, 32'shaaaa_aaaa));
    send_op(make_op(FUNC_DELETE, 32'sh5555_5555));
    send_op(make_op(FUNC_DELETE, 32'shaaaa_aaaa));
    send_op(make_op(FUNC_DELETE, 1));
    send_op(make_op(FUNC_DELETE, 0));
    send_op(make_op(FUNC_DELETE, 0));
    send_op(make_op(FUNC_DELETE, 32'sh7fff_ffff));
    send_op(make_op(FUNC_DELETE, 0));
    in_valid <= 1'b0;

    run_phase(160, 85, 12);
    wait_drained();
    hold_len = 300;
    run_phase(40, 60, 0);
    run_phase(120, 50, 0);
    run_phase(180, 15, 12);
    wait_drained();
    for (int p = 0; p < 6; p++) begin
      run_phase(200, (p % 2 == 0) ? 75 : 35, (p % 3 == 1) ? 0 : 12);
    end

    wait_drained();
    repeat (16) @(posedge clk);
    $display("covered %0d transactions and %0d results, peak occupancy %0d of %0d",
             sent, tracker.checked, tracker.peak, DEPTH);
    $display("inserts refused when full: %0d, deletes of absent values: %0d, mismatches: %0d",
             tracker.refused_full, tracker.absent_deletes, tracker.mismatches);
    if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/slsi_pkg.sv
rtl/slsi_cell.sv
rtl/slsi_or_tree.sv
rtl/sorted_list_insert_delete.sv
rtl/slsi_checker.sv
test/tb_sorted_list_insert_delete.sv
